[design/hse_pkg.sv]
`default_nettype none

package hse_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_NEXT,
        ST_SWAP_ROOT,
        ST_SWAP_TAIL,
        ST_HELD,
        ST_CHILD,
        ST_LEFT,
        ST_RIGHT,
        ST_CMP,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_EMIT_WAIT
    } state_t;

endpackage

`default_nettype wire

[design/hse_ram.sv]
`default_nettype none

module hse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[design/heap_sort_engine.sv]
`default_nettype none

// Heapsort engine. Values are loaded one item per cycle until the item marked
// last; values beyond MAX_ITEMS are dropped, but the last mark still ends the
// load. The block then builds a max-heap and sorts in place, and emits every
// held value in ascending order with last_res on the final one. in_stall is
// high from the end of the load until the final sorted item has been taken.
// All work goes through one heap RAM with a single read port, so each sift
// level runs the child test, the left read, the right read when a right
// child exists, and the compare and write, in both the build and the
// extraction phases; emission reads each item, registers it on value_res and
// holds it until it is taken before it moves on to the next.
module heap_sort_engine #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] value,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      value_res,
    output logic                    last_res
);

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned KW = AW + 2;
    localparam int unsigned DW = hse_pkg::DATA_W;
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    hse_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] hn_reg, hn_next;
    logic          sort_phase_reg, sort_phase_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] big_idx_reg, big_idx_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic signed [DW-1:0] held_reg, held_next;
    logic signed [DW-1:0] big_reg, big_next;
    logic [DW-1:0]        root_reg, root_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [DW-1:0] value_res_reg, value_res_next;
    logic                 last_res_reg, last_res_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic [KW-1:0] kid;
    logic [KW-1:0] kid_p1;
    logic [KW-1:0] hn_ext;
    logic [CW-1:0] k_m1;
    logic [CW-1:0] cnt_inc;
    logic          in_acc;

    hse_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_ITEMS)
    ) u_heap_ram (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign kid     = KW'({pos_reg, 1'b1});
    assign kid_p1  = kid + KW'(1);
    assign hn_ext  = KW'(hn_reg);
    assign k_m1    = k_reg - ONE_C;
    assign cnt_inc = count_reg + ONE_C;
    assign in_acc  = in_valid && !in_stall;

    assign in_stall  = (state_reg != hse_pkg::ST_LOAD);
    assign out_valid = out_valid_reg;
    assign value_res = value_res_reg;
    assign last_res  = last_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hse_pkg::ST_LOAD;
            count_reg      <= '0;
            sort_phase_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            sort_phase_reg <= sort_phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        k_reg         <= k_next;
        hn_reg        <= hn_next;
        pos_reg       <= pos_next;
        big_idx_reg   <= big_idx_next;
        idx_reg       <= idx_next;
        held_reg      <= held_next;
        big_reg       <= big_next;
        root_reg      <= root_next;
        value_res_reg <= value_res_next;
        last_res_reg  <= last_res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        hn_next         = hn_reg;
        sort_phase_next = sort_phase_reg;
        pos_next        = pos_reg;
        big_idx_next    = big_idx_reg;
        idx_next        = idx_reg;
        held_next       = held_reg;
        big_next        = big_reg;
        root_next       = root_reg;
        out_valid_next  = out_valid_reg;
        value_res_next  = value_res_reg;
        last_res_next   = last_res_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = held_reg;
        ram_raddr       = kid[AW-1:0];

        unique case (state_reg)
            hse_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < MAX_C)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = value;
                        count_next = cnt_inc;
                    end
                    if (last)
                    begin
                        n_next          = (count_reg < MAX_C) ? cnt_inc : count_reg;
                        k_next          = n_next >> 1;
                        sort_phase_next = 1'b0;
                        state_next      = hse_pkg::ST_NEXT;
                    end
                end
            end

            hse_pkg::ST_NEXT:
            begin
                if (!sort_phase_reg)
                begin
                    if (k_reg != '0)
                    begin
                        ram_raddr  = k_m1[AW-1:0];
                        pos_next   = k_m1[AW-1:0];
                        hn_next    = n_reg;
                        k_next     = k_m1;
                        state_next = hse_pkg::ST_HELD;
                    end
                    else
                    begin
                        sort_phase_next = 1'b1;
                        k_next          = n_reg;
                    end
                end
                else if (k_reg > ONE_C)
                begin
                    ram_raddr  = '0;
                    state_next = hse_pkg::ST_SWAP_ROOT;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = hse_pkg::ST_EMIT_RD;
                end
            end

            hse_pkg::ST_SWAP_ROOT:
            begin
                root_next  = ram_rdata;
                ram_raddr  = k_m1[AW-1:0];
                state_next = hse_pkg::ST_SWAP_TAIL;
            end

            hse_pkg::ST_SWAP_TAIL:
            begin
                held_next  = $signed(ram_rdata);
                ram_we     = 1'b1;
                ram_waddr  = k_m1[AW-1:0];
                ram_wdata  = root_reg;
                pos_next   = '0;
                hn_next    = k_m1;
                k_next     = k_m1;
                state_next = hse_pkg::ST_CHILD;
            end

            hse_pkg::ST_HELD:
            begin
                held_next  = $signed(ram_rdata);
                state_next = hse_pkg::ST_CHILD;
            end

            hse_pkg::ST_CHILD:
            begin
                if (kid >= hn_ext)
                begin
                    ram_we     = 1'b1;
                    state_next = hse_pkg::ST_NEXT;
                end
                else
                begin
                    ram_raddr  = kid[AW-1:0];
                    state_next = hse_pkg::ST_LEFT;
                end
            end

            hse_pkg::ST_LEFT:
            begin
                big_next     = $signed(ram_rdata);
                big_idx_next = kid[AW-1:0];
                if (kid_p1 < hn_ext)
                begin
                    ram_raddr  = kid_p1[AW-1:0];
                    state_next = hse_pkg::ST_RIGHT;
                end
                else
                begin
                    state_next = hse_pkg::ST_CMP;
                end
            end

            hse_pkg::ST_RIGHT:
            begin
                if ($signed(ram_rdata) > big_reg)
                begin
                    big_next     = $signed(ram_rdata);
                    big_idx_next = kid_p1[AW-1:0];
                end
                state_next = hse_pkg::ST_CMP;
            end

            hse_pkg::ST_CMP:
            begin
                ram_we = 1'b1;
                if (big_reg > held_reg)
                begin
                    ram_wdata  = big_reg;
                    pos_next   = big_idx_reg;
                    state_next = hse_pkg::ST_CHILD;
                end
                else
                begin
                    state_next = hse_pkg::ST_NEXT;
                end
            end

            hse_pkg::ST_EMIT_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = hse_pkg::ST_EMIT_OUT;
            end

            hse_pkg::ST_EMIT_OUT:
            begin
                value_res_next = $signed(ram_rdata);
                last_res_next  = ((CW'(idx_reg) + ONE_C) == n_reg);
                out_valid_next = 1'b1;
                state_next     = hse_pkg::ST_EMIT_WAIT;
            end

            hse_pkg::ST_EMIT_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (last_res_reg)
                    begin
                        count_next = '0;
                        state_next = hse_pkg::ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = hse_pkg::ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = hse_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire
